/* design/mccs_pkg.sv */
package mccs_pkg;

   // Fixed field widths
   localparam int PIX_W  = 8;
   localparam int GAIN_W = 10;
   localparam int MEAN_W = 16;
   localparam int FRAC_W = 8;
   localparam int LANES  = 3;

   // Apply arithmetic widths: diff is signed Q8, the product and value are signed Q16
   localparam int DIFF_W = MEAN_W + 2;
   localparam int PROD_W = DIFF_W + GAIN_W + 1;
   localparam int VAL_W  = PROD_W + 1;

   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(320);

   // Request codes
   localparam logic REQ_ACCUM = 1'b0;
   localparam logic REQ_APPLY = 1'b1;

   // Lane order
   localparam int LANE_BLUE  = 0;
   localparam int LANE_GREEN = 1;
   localparam int LANE_RED   = 2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } mccs_state_type;

   typedef struct packed {
      logic acc_en;
      logic div_load;
      logic div_step;
      logic div_finish;
      logic adv;
   } mccs_cmd_type;

endpackage

/* design/mean_centered_contrast_stretch_core.sv */
// Apply beat: result via multiply and clamp registers; one pixel per cycle, stalls on rsp_stall.
// Accumulate beat: one pixel per cycle, no result; stalls on rsp_stall too.
// A frame_end accumulate beat stalls the request side until the means are written:
// a restoring divider produces one quotient bit per cycle for all three channels at once.
// Synchronous active-high reset clears sums, tally and means to zero and sets gain to 1.25.
module mean_centered_contrast_stretch_core
   import mccs_pkg::*;
#(
   parameter int PIXEL_COUNT_BITS = 22
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_type,
   input  logic [PIX_W-1:0]  req_pixel_blue,
   input  logic [PIX_W-1:0]  req_pixel_green,
   input  logic [PIX_W-1:0]  req_pixel_red,
   input  logic              req_frame_end,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [PIX_W-1:0]  rsp_out_blue,
   output logic [PIX_W-1:0]  rsp_out_green,
   output logic [PIX_W-1:0]  rsp_out_red,
   output logic              rsp_clipped,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [GAIN_W-1:0] csr_contrast_gain
);

   mccs_cmd_type cmd;
   logic         busy;

   assign csr_ready = 1'b1;

   mccs_ctrl #(
      .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_type      (req_type),
      .req_frame_end (req_frame_end),
      .rsp_stall     (rsp_stall),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .busy          (busy),
      .cmd           (cmd)
   );

   mccs_dpath #(
      .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .gain_wr     (csr_valid && csr_ready),
      .gain_data   (csr_contrast_gain),
      .pixel_blue  (req_pixel_blue),
      .pixel_green (req_pixel_green),
      .pixel_red   (req_pixel_red),
      .out_blue    (rsp_out_blue),
      .out_green   (rsp_out_green),
      .out_red     (rsp_out_red),
      .clipped     (rsp_clipped)
   );

   // no beat is taken while the means are being computed
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      busy |-> req_stall)
      else $error("request accepted during mean computation");

   // a frame end beat starts the divider
   a_frame_end_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_type == REQ_ACCUM) && req_frame_end) |=> busy)
      else $error("frame end did not start mean computation");

   // a waiting result freezes the whole apply pipeline
   a_output_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("request accepted while output beat waits");

endmodule

/* design/mccs_ctrl.sv */
module mccs_ctrl
   import mccs_pkg::*;
#(
   parameter int PIXEL_COUNT_BITS = 22
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_type,
   input  logic         req_frame_end,
   input  logic         rsp_stall,
   output logic         req_stall,
   output logic         rsp_valid,
   output logic         busy,
   output mccs_cmd_type cmd
);

   localparam int DIV_STEPS = PIXEL_COUNT_BITS + 8 + FRAC_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   mccs_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             s1_valid_ff, s1_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             adv;
   logic             accept;

   // State and pipeline valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state, handshake and datapath commands
   always_comb begin
      adv       = !(rsp_valid_ff && rsp_stall);
      req_stall = (state_ff != ST_IDLE) || !adv;
      accept    = req_valid && !req_stall;

      cmd.adv        = adv;
      cmd.acc_en     = accept && (req_type == REQ_ACCUM);
      cmd.div_load   = accept && (req_type == REQ_ACCUM) && req_frame_end;
      cmd.div_step   = (state_ff == ST_DIVIDE);
      cmd.div_finish = (state_ff == ST_FINISH);

      // advance the apply pipeline as one unit, hold it while the output beat waits
      s1_valid_in  = adv ? (accept && (req_type == REQ_APPLY)) : s1_valid_ff;
      rsp_valid_in = adv ? s1_valid_ff : rsp_valid_ff;

      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (cmd.div_load) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign busy      = (state_ff != ST_IDLE);

endmodule

/* design/mccs_dpath.sv */
module mccs_dpath
   import mccs_pkg::*;
#(
   parameter int PIXEL_COUNT_BITS = 22
) (
   input  logic              clock,
   input  logic              reset,
   input  mccs_cmd_type      cmd,
   input  logic              gain_wr,
   input  logic [GAIN_W-1:0] gain_data,
   input  logic [PIX_W-1:0]  pixel_blue,
   input  logic [PIX_W-1:0]  pixel_green,
   input  logic [PIX_W-1:0]  pixel_red,
   output logic [PIX_W-1:0]  out_blue,
   output logic [PIX_W-1:0]  out_green,
   output logic [PIX_W-1:0]  out_red,
   output logic              clipped
);

   localparam int SUM_W = PIXEL_COUNT_BITS + PIX_W;
   localparam int TAL_W = PIXEL_COUNT_BITS + 1;
   localparam int QUO_W = SUM_W + FRAC_W;
   localparam int TRY_W = TAL_W + 1;

   localparam logic signed [VAL_W-1:0] LOW_LIMIT = -(VAL_W'(1) << 16);

   logic [GAIN_W-1:0] gain_ff;
   logic [SUM_W-1:0]  sum_ff   [LANES];
   logic [TAL_W-1:0]  tally_ff;
   logic [MEAN_W-1:0] mean_ff  [LANES];
   logic [QUO_W-1:0]  quo_ff   [LANES];
   logic [TAL_W-1:0]  rem_ff   [LANES];
   logic [TAL_W-1:0]  divisor_ff;

   logic signed [VAL_W-1:0] val_ff [LANES];
   logic [PIX_W-1:0]        chan_ff [LANES];
   logic                    clip_ff;

   logic [PIX_W-1:0]        pix       [LANES];
   logic [SUM_W:0]          sum_wide  [LANES];
   logic [SUM_W-1:0]        sum_sat   [LANES];
   logic [TAL_W:0]          tally_wide;
   logic [TAL_W-1:0]        tally_sat;
   logic [TRY_W-1:0]        trial     [LANES];
   logic [TRY_W-1:0]        trial_sub [LANES];
   logic                    q_bit     [LANES];
   logic signed [DIFF_W-1:0] diff     [LANES];
   logic signed [PROD_W-1:0] prod     [LANES];
   logic signed [VAL_W-1:0]  val      [LANES];
   logic [PIX_W-1:0]        chan      [LANES];
   logic [LANES-1:0]        clip_lane;

   assign pix[LANE_BLUE]  = pixel_blue;
   assign pix[LANE_GREEN] = pixel_green;
   assign pix[LANE_RED]   = pixel_red;

   // Saturating sums, divider trial subtract and apply arithmetic per lane
   always_comb begin
      tally_wide = {1'b0, tally_ff} + (TAL_W + 1)'(1);
      tally_sat  = tally_wide[TAL_W] ? {TAL_W{1'b1}} : tally_wide[TAL_W-1:0];
      for (int i = 0; i < LANES; i++) begin
         sum_wide[i] = {1'b0, sum_ff[i]} + (SUM_W + 1)'(pix[i]);
         sum_sat[i]  = sum_wide[i][SUM_W] ? {SUM_W{1'b1}} : sum_wide[i][SUM_W-1:0];

         trial[i]     = {rem_ff[i], quo_ff[i][QUO_W-1]};
         trial_sub[i] = trial[i] - {1'b0, divisor_ff};
         q_bit[i]     = (trial[i] >= {1'b0, divisor_ff});

         diff[i] = $signed({2'b00, mean_ff[i]}) - $signed({2'b00, pix[i], {FRAC_W{1'b0}}});
         prod[i] = diff[i] * $signed({1'b0, gain_ff});
         val[i]  = $signed({{(VAL_W - MEAN_W - FRAC_W){1'b0}}, mean_ff[i], {FRAC_W{1'b0}}})
                   - VAL_W'(prod[i]);

         // truncate toward zero, then clamp: values in (-1, 0) give zero without a flag
         if (val_ff[i][VAL_W-1]) begin
            chan[i]      = '0;
            clip_lane[i] = (val_ff[i] <= LOW_LIMIT);
         end else if (|val_ff[i][VAL_W-2:24]) begin
            chan[i]      = {PIX_W{1'b1}};
            clip_lane[i] = 1'b1;
         end else begin
            chan[i]      = val_ff[i][23:16];
            clip_lane[i] = 1'b0;
         end
      end
   end

   // Gain register, statistics and means
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= GAIN_RESET;
         tally_ff <= '0;
         for (int i = 0; i < LANES; i++) begin
            sum_ff[i]  <= '0;
            mean_ff[i] <= '0;
         end
      end else begin
         if (gain_wr) begin
            gain_ff <= gain_data;
         end
         if (cmd.acc_en) begin
            tally_ff <= cmd.div_load ? '0 : tally_sat;
            for (int i = 0; i < LANES; i++) begin
               sum_ff[i] <= cmd.div_load ? '0 : sum_sat[i];
            end
         end
         if (cmd.div_finish) begin
            for (int i = 0; i < LANES; i++) begin
               mean_ff[i] <= (|quo_ff[i][QUO_W-1:MEAN_W]) ? {MEAN_W{1'b1}}
                                                          : quo_ff[i][MEAN_W-1:0];
            end
         end
      end
   end

   // Restoring divider, one quotient bit per lane per step
   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         divisor_ff <= tally_sat;
         for (int i = 0; i < LANES; i++) begin
            quo_ff[i] <= {sum_sat[i], {FRAC_W{1'b0}}};
            rem_ff[i] <= '0;
         end
      end else if (cmd.div_step) begin
         for (int i = 0; i < LANES; i++) begin
            quo_ff[i] <= {quo_ff[i][QUO_W-2:0], q_bit[i]};
            rem_ff[i] <= q_bit[i] ? trial_sub[i][TAL_W-1:0] : trial[i][TAL_W-1:0];
         end
      end
   end

   // Apply pipeline: multiply stage, then clamp into the output beat
   always_ff @(posedge clock) begin
      if (cmd.adv) begin
         for (int i = 0; i < LANES; i++) begin
            val_ff[i]  <= val[i];
            chan_ff[i] <= chan[i];
         end
         clip_ff <= |clip_lane;
      end
   end

   assign out_blue  = chan_ff[LANE_BLUE];
   assign out_green = chan_ff[LANE_GREEN];
   assign out_red   = chan_ff[LANE_RED];
   assign clipped   = clip_ff;

endmodule
